[rtl/core/gsrp_pkg.sv]
// ----------------------------------------------------------------------------
// gsrp_pkg
// Shared constants, codes and types of the generational slot record pool.
// ----------------------------------------------------------------------------
package gsrp_pkg;

	localparam int SLOTS            = 32;
	localparam int RECORDS_PER_SLOT = 16;

	localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int REC_W      = (RECORDS_PER_SLOT > 1) ? $clog2(RECORDS_PER_SLOT) : 1;
	localparam int FILL_W     = $clog2(RECORDS_PER_SLOT + 1);
	localparam int REC_ADDR_W = SLOT_W + REC_W;
	localparam int REC_DEPTH  = 1 << REC_ADDR_W;

	localparam int IN_DATA_W  = 80;
	localparam int IN_USER_W  = 6;
	localparam int OUT_DATA_W = 112;
	localparam int OUT_USER_W = 4;

	localparam logic [15:0] NULL_SLOT       = 16'hFFFF;
	localparam logic [15:0] GEN_RESET       = 16'd1;
	localparam logic [15:0] GEN_MAX         = 16'hFFFF;
	localparam logic [15:0] ARENA_LIMIT_RST = 16'hFFFF;
	localparam logic [7:0]  USER_PROP_ID    = 8'd38;
	localparam logic [2:0]  KIND_USER       = 3'd6;

	typedef enum logic [2:0] {
		CMD_ACQUIRE = 3'd0,
		CMD_RELEASE = 3'd1,
		CMD_ADD     = 3'd2,
		CMD_COUNT   = 3'd3,
		CMD_READ    = 3'd4
	} cmd_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [15:0] slot;
		logic [15:0] generation;
		logic [7:0]  prop_id;
		logic [2:0]  kind;
		logic [15:0] value_len;
		logic [15:0] key_len;
		logic [3:0]  rd_index;
	} item_t;

	typedef struct packed {
		logic        ok;
		logic [15:0] slot_out;
		logic [15:0] generation_out;
		logic [4:0]  count_out;
		logic [7:0]  rec_id;
		logic [2:0]  rec_kind;
		logic [15:0] rec_offset;
		logic [15:0] rec_length;
		logic [15:0] rec_key_base;
		logic [15:0] rec_key_size;
	} result_t;

	typedef struct packed {
		logic [7:0]  id;
		logic [2:0]  kind;
		logic [15:0] value_offset;
		logic [15:0] value_length;
		logic [15:0] key_base;
		logic [15:0] key_size;
	} rec_t;

	localparam int REC_BITS = $bits(rec_t);

	typedef struct packed {
		logic acquire;
		logic release_slot;
		logic append;
	} slot_upd_t;

	typedef struct packed {
		logic              free_any;
		logic [SLOT_W-1:0] free_idx;
		logic [SLOT_W-1:0] idx;
		logic              busy;
		logic [15:0]       generation;
		logic [FILL_W-1:0] fill;
	} slot_stat_t;

	typedef struct packed {
		logic        ok;
		logic [15:0] key_base;
		logic [15:0] value_offset;
	} arena_res_t;

endpackage

[rtl/core/generational_slot_record_pool.sv]
// ----------------------------------------------------------------------------
// generational_slot_record_pool
// Slot pool with generation-checked handles and per-slot property records.
// ----------------------------------------------------------------------------
// One word is accepted in every cycle in which the master side is not
// stalled: the word is registered together with the record-store read, one
// pass of slot lookup, arena reservation and checks follows, and the result
// is registered on the master side, where it is offered. Only m_axis_tready
// held low slows the block down. The record store is a single RAM of
// SLOTS x RECORDS_PER_SLOT entries with one write and one read port; its
// contents are undefined until written, so there is no clearing pass after
// reset. arena_limit is written through cfg_we/cfg_wdata; the user must
// write it only while the block is idle, which the block does not enforce.
// Reset sets it to 65535.
module generational_slot_record_pool (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [15:0]                      cfg_wdata,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// slot, generation, prop_id, value_len, key_len, read index, zero pad
	input  logic [gsrp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// cmd, kind
	input  logic [gsrp_pkg::IN_USER_W-1:0]   s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// slot_out, generation_out, count_out, rec_id, rec_offset, rec_length,
	// rec key offset, rec key length, zero pad
	output logic [gsrp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// ok, rec_kind
	output logic [gsrp_pkg::OUT_USER_W-1:0]  m_axis_tuser
);

	gsrp_pkg::item_t       in_item;
	gsrp_pkg::item_t       item_s1;
	logic                  valid_s1;
	logic                  byp_s1;
	gsrp_pkg::rec_t        byp_rec_s1;
	gsrp_pkg::result_t     res;
	gsrp_pkg::result_t     res_q;
	logic                  m_valid_q;
	logic                  advance;
	logic                  accept;
	logic                  commit;

	gsrp_pkg::slot_upd_t   upd;
	gsrp_pkg::slot_stat_t  stat;
	gsrp_pkg::arena_res_t  ares;
	gsrp_pkg::rec_t        wrec;
	gsrp_pkg::rec_t        ram_rdata;
	gsrp_pkg::rec_t        rrec;
	logic [gsrp_pkg::REC_ADDR_W-1:0] raddr;
	logic [gsrp_pkg::REC_ADDR_W-1:0] waddr;
	logic                  ram_we;
	logic                  is_add;
	logic                  is_user;
	logic                  handle_ok;
	logic                  add_ok;
	logic                  full;

	always_comb begin
		in_item.cmd        = s_axis_tuser[2:0];
		in_item.kind       = s_axis_tuser[5:3];
		in_item.slot       = s_axis_tdata[15:0];
		in_item.generation = s_axis_tdata[31:16];
		in_item.prop_id    = s_axis_tdata[39:32];
		in_item.value_len  = s_axis_tdata[55:40];
		in_item.key_len    = s_axis_tdata[71:56];
		in_item.rd_index   = s_axis_tdata[75:72];
	end

	assign advance       = !m_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign commit        = valid_s1 && advance;

	// record store: read at accept, written when a stage-1 add that passes its checks moves on
	assign raddr = {in_item.slot[gsrp_pkg::SLOT_W-1:0], gsrp_pkg::REC_W'(in_item.rd_index)};
	assign waddr = {stat.idx, stat.fill[gsrp_pkg::REC_W-1:0]};

	gsrp_ram #(
		.WIDTH(gsrp_pkg::REC_BITS),
		.DEPTH(gsrp_pkg::REC_DEPTH)
	) u_rec_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (wrec),
		.re    (accept),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byp_s1   <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				byp_s1   <= ram_we && (waddr == raddr);
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1    <= in_item;
			byp_rec_s1 <= wrec;
		end
	end

	assign rrec = byp_s1 ? byp_rec_s1 : ram_rdata;

	gsrp_slot_table u_slots (
		.clk      (clk),
		.arst_n   (arst_n),
		.acquire  (item_s1.cmd == gsrp_pkg::CMD_ACQUIRE),
		.slot_idx (item_s1.slot[gsrp_pkg::SLOT_W-1:0]),
		.upd      (upd),
		.stat     (stat)
	);

	assign is_add = (item_s1.cmd == gsrp_pkg::CMD_ADD);

	gsrp_arena u_arena (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.commit    (commit && is_add),
		.kind      (item_s1.kind),
		.key_len   (item_s1.key_len),
		.value_len (item_s1.value_len),
		.res       (ares)
	);

	assign handle_ok = (item_s1.slot != gsrp_pkg::NULL_SLOT)
		&& (item_s1.slot < 16'(gsrp_pkg::SLOTS))
		&& stat.busy && (stat.generation == item_s1.generation);
	assign full    = (stat.fill >= gsrp_pkg::FILL_W'(gsrp_pkg::RECORDS_PER_SLOT));
	assign add_ok  = ares.ok && handle_ok && !full;
	assign is_user = (item_s1.kind == gsrp_pkg::KIND_USER);
	assign ram_we  = commit && is_add && add_ok;

	always_comb begin
		wrec.id           = is_user ? gsrp_pkg::USER_PROP_ID : item_s1.prop_id;
		wrec.kind         = item_s1.kind;
		wrec.value_offset = ares.value_offset;
		wrec.value_length = item_s1.value_len;
		wrec.key_base     = is_user ? ares.key_base : 16'd0;
		wrec.key_size     = is_user ? item_s1.key_len : 16'd0;
	end

	always_comb begin
		res          = '0;
		res.slot_out = gsrp_pkg::NULL_SLOT;
		upd          = '0;
		case (item_s1.cmd)
			gsrp_pkg::CMD_ACQUIRE: begin
				if (stat.free_any) begin
					res.ok             = 1'b1;
					res.slot_out       = 16'(stat.free_idx);
					res.generation_out = stat.generation;
					upd.acquire        = commit;
				end
			end
			gsrp_pkg::CMD_RELEASE: begin
				if (handle_ok) begin
					res.ok           = 1'b1;
					upd.release_slot = commit;
				end
			end
			gsrp_pkg::CMD_ADD: begin
				if (add_ok) begin
					res.ok     = 1'b1;
					upd.append = commit;
				end
			end
			gsrp_pkg::CMD_COUNT: begin
				if (handle_ok) begin
					res.ok        = 1'b1;
					res.count_out = 5'(stat.fill);
				end
			end
			gsrp_pkg::CMD_READ: begin
				if (handle_ok) begin
					res.count_out = 5'(stat.fill);
					if ({1'b0, item_s1.rd_index} < 5'(stat.fill)) begin
						res.ok           = 1'b1;
						res.rec_id       = rrec.id;
						res.rec_kind     = rrec.kind;
						res.rec_offset   = rrec.value_offset;
						res.rec_length   = rrec.value_length;
						res.rec_key_base = rrec.key_base;
						res.rec_key_size = rrec.key_size;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {3'b000, res_q.rec_key_size, res_q.rec_key_base,
		res_q.rec_length, res_q.rec_offset, res_q.rec_id, res_q.count_out,
		res_q.generation_out, res_q.slot_out};
	assign m_axis_tuser  = {res_q.rec_kind, res_q.ok};

endmodule

[rtl/core/gsrp_ram.sv]
// ----------------------------------------------------------------------------
// gsrp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gsrp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/gsrp_slot_table.sv]
// ----------------------------------------------------------------------------
// gsrp_slot_table
// Per-slot busy, generation and fill state with lowest-free-slot search.
// ----------------------------------------------------------------------------
module gsrp_slot_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        acquire,
	input  logic [gsrp_pkg::SLOT_W-1:0] slot_idx,
	input  gsrp_pkg::slot_upd_t         upd,
	output gsrp_pkg::slot_stat_t        stat
);

	logic [gsrp_pkg::SLOTS-1:0]  busy_q;
	logic [15:0]                 gen_q  [gsrp_pkg::SLOTS];
	logic [gsrp_pkg::FILL_W-1:0] fill_q [gsrp_pkg::SLOTS];
	logic                        free_any;
	logic [gsrp_pkg::SLOT_W-1:0] free_idx;
	logic [gsrp_pkg::SLOT_W-1:0] look;

	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = gsrp_pkg::SLOTS - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_any = 1'b1;
				free_idx = gsrp_pkg::SLOT_W'(i);
			end
		end
	end

	assign look = acquire ? free_idx : slot_idx;

	always_comb begin
		stat.free_any   = free_any;
		stat.free_idx   = free_idx;
		stat.idx        = look;
		stat.busy       = busy_q[look];
		stat.generation = gen_q[look];
		stat.fill       = fill_q[look];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			for (int i = 0; i < gsrp_pkg::SLOTS; i++) begin
				gen_q[i]  <= gsrp_pkg::GEN_RESET;
				fill_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < gsrp_pkg::SLOTS; i++) begin
				if (look == gsrp_pkg::SLOT_W'(i)) begin
					if (upd.acquire) begin
						busy_q[i] <= 1'b1;
						fill_q[i] <= '0;
					end else if (upd.release_slot) begin
						busy_q[i] <= 1'b0;
						fill_q[i] <= '0;
						// generation wraps past zero
						gen_q[i]  <= (gen_q[i] == gsrp_pkg::GEN_MAX) ?
							gsrp_pkg::GEN_RESET : gen_q[i] + 16'd1;
					end else if (upd.append) begin
						fill_q[i] <= fill_q[i] + gsrp_pkg::FILL_W'(1);
					end
				end
			end
		end
	end

endmodule

[rtl/core/gsrp_arena.sv]
// ----------------------------------------------------------------------------
// gsrp_arena
// Bump-pointer arena reservation of key then value, with limit register.
// ----------------------------------------------------------------------------
module gsrp_arena (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [15:0]           cfg_wdata,
	input  logic                  commit,
	input  logic [2:0]            kind,
	input  logic [15:0]           key_len,
	input  logic [15:0]           value_len,
	output gsrp_pkg::arena_res_t  res
);

	logic [15:0] limit_q;
	logic [15:0] used_q;
	logic [16:0] sum_k;
	logic [16:0] sum_v;
	logic [15:0] base_v;
	logic        is_user;
	logic        kind_ok;
	logic        k_fit;
	logic        v_fit;
	logic        key_go;
	logic        val_go;

	assign is_user = (kind == gsrp_pkg::KIND_USER);
	assign kind_ok = (kind <= gsrp_pkg::KIND_USER);
	assign sum_k   = {1'b0, used_q} + {1'b0, key_len};
	assign k_fit   = (sum_k <= {1'b0, limit_q});
	assign base_v  = is_user ? sum_k[15:0] : used_q;
	assign sum_v   = {1'b0, base_v} + {1'b0, value_len};
	assign v_fit   = (sum_v <= {1'b0, limit_q});

	assign key_go = kind_ok && is_user && k_fit;
	assign val_go = kind_ok && (!is_user || k_fit) && v_fit;

	always_comb begin
		res.ok           = val_go;
		res.key_base     = used_q;
		res.value_offset = base_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= gsrp_pkg::ARENA_LIMIT_RST;
			used_q  <= '0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			// key space stays taken when the value does not fit
			if (commit) begin
				if (val_go) begin
					used_q <= sum_v[15:0];
				end else if (key_go) begin
					used_q <= sum_k[15:0];
				end
			end
		end
	end

endmodule

[rtl/core/gsrp_checker.sv]
// ----------------------------------------------------------------------------
// gsrp_checker
// Port-level checks of the slot pool's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module gsrp_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [gsrp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input logic [gsrp_pkg::OUT_USER_W-1:0]  m_axis_tuser
);

	// stalled result word is held
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("result word changed while stalled");

	// failed command: null slot, zero generation, no record fields
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[15:0] == 16'hFFFF
		&& m_axis_tdata[31:16] == 16'd0 && m_axis_tdata[111:37] == '0
		&& m_axis_tuser[3:1] == 3'd0)
		else $error("failed result carries data");

	// acquire result: generation is never zero, count and record fields are clear
	a_acq_gen: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] && m_axis_tdata[15:0] != 16'hFFFF
		|-> m_axis_tdata[31:16] != 16'd0 && m_axis_tdata[111:32] == '0
		&& m_axis_tuser[3:1] == 3'd0)
		else $error("acquire result malformed");

	// records per slot never exceed the limit
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[36:32] <= 5'(gsrp_pkg::RECORDS_PER_SLOT))
		else $error("record count out of range");

endmodule

bind generational_slot_record_pool gsrp_checker u_gsrp_checker (.*);

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stream-level testbench for the generational slot record pool.
// ----------------------------------------------------------------------------
// A directed table runs first. It covers the null handle, acquire and
// release, every value kind including the bad one, stale handles, reads
// past the count, unused commands and a limit lowered below use. Random
// phases follow at several arena limits. Each random word is mostly a live
// handle on a low slot, so slots fill up to their record cap. Results are
// checked field by field against the table where a row gives them, else
// against the pool model. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int PHASE_WORDS = 315;

	localparam logic [2:0] CMD_SPARE_LO = 3'd5;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;
	localparam logic [2:0] KIND_BYTE    = 3'd0;
	localparam logic [2:0] KIND_U16     = 3'd1;
	localparam logic [2:0] KIND_U32     = 3'd2;
	localparam logic [2:0] KIND_VARINT  = 3'd3;
	localparam logic [2:0] KIND_UTF8    = 3'd4;
	localparam logic [2:0] KIND_BINARY  = 3'd5;
	localparam logic [2:0] KIND_BAD     = 3'd7;

	typedef struct packed {
		gsrp_pkg::item_t   w;
		logic              is_cfg;
		logic [15:0]       cfg_val;
		logic              typed;
		gsrp_pkg::result_t want;
	} row_t;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_we;
	logic [15:0]                      cfg_wdata;
	logic                             s_axis_tvalid;
	logic                             s_axis_tready;
	logic [gsrp_pkg::IN_DATA_W-1:0]   s_axis_tdata;
	logic [gsrp_pkg::IN_USER_W-1:0]   s_axis_tuser;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready;
	logic [gsrp_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
	logic [gsrp_pkg::OUT_USER_W-1:0]  m_axis_tuser;

	// pool model
	logic           pool_busy [gsrp_pkg::SLOTS];
	logic [15:0]    pool_gen  [gsrp_pkg::SLOTS];
	logic [4:0]     pool_fill [gsrp_pkg::SLOTS];
	gsrp_pkg::rec_t pool_recs [gsrp_pkg::SLOTS*gsrp_pkg::RECORDS_PER_SLOT];
	int             arena_top;
	int             arena_cap;

	gsrp_pkg::result_t pending_results [$];
	row_t              plan [$];
	int                mismatches;
	int                cycle_count;
	int                stall_left;
	bit                burst;
	bit                calm;
	gsrp_pkg::result_t seen;
	gsrp_pkg::result_t owed;

	generational_slot_record_pool uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #2 clk = ~clk;

	function automatic gsrp_pkg::result_t pool_outcome(input gsrp_pkg::item_t w);
		gsrp_pkg::result_t r;
		bit                live;
		bit                room;
		int                s;
		int                idx;
		logic [15:0]       koff;
		logic [15:0]       voff;
		logic [15:0]       klen;
		logic [7:0]        id;
		bit                found;
		r = '0;
		r.slot_out = gsrp_pkg::NULL_SLOT;
		s = w.slot;
		live = (w.slot != gsrp_pkg::NULL_SLOT) && (s < gsrp_pkg::SLOTS);
		if (live)
			live = pool_busy[s] && (pool_gen[s] == w.generation);
		case (w.cmd)
			gsrp_pkg::CMD_ACQUIRE: begin
				found = 0;
				for (int i = 0; i < gsrp_pkg::SLOTS; i++) begin
					if (!found && !pool_busy[i]) begin
						found = 1;
						pool_busy[i] = 1'b1;
						pool_fill[i] = '0;
						r.ok = 1'b1;
						r.slot_out = 16'(i);
						r.generation_out = pool_gen[i];
					end
				end
			end
			gsrp_pkg::CMD_RELEASE: begin
				if (live) begin
					pool_busy[s] = 1'b0;
					pool_fill[s] = '0;
					pool_gen[s] = pool_gen[s] + 16'd1;
					if (pool_gen[s] == '0)
						pool_gen[s] = gsrp_pkg::GEN_RESET;
					r.ok = 1'b1;
				end
			end
			gsrp_pkg::CMD_ADD: begin
				room = (w.kind <= gsrp_pkg::KIND_USER);
				koff = '0;
				voff = '0;
				klen = '0;
				id = w.prop_id;
				// key space is taken first and kept even if the value fails
				if (room && w.kind == gsrp_pkg::KIND_USER) begin
					if (arena_top + int'(w.key_len) > arena_cap) begin
						room = 0;
					end else begin
						koff = 16'(arena_top);
						arena_top += w.key_len;
						klen = w.key_len;
						id = gsrp_pkg::USER_PROP_ID;
					end
				end
				if (room) begin
					if (arena_top + int'(w.value_len) > arena_cap) begin
						room = 0;
					end else begin
						voff = 16'(arena_top);
						arena_top += w.value_len;
					end
				end
				if (room && live && pool_fill[s] < gsrp_pkg::RECORDS_PER_SLOT) begin
					idx = s * gsrp_pkg::RECORDS_PER_SLOT + pool_fill[s];
					pool_recs[idx] = '{id, w.kind, voff, w.value_len, koff, klen};
					pool_fill[s] = pool_fill[s] + 5'd1;
					r.ok = 1'b1;
				end
			end
			gsrp_pkg::CMD_COUNT: begin
				if (live) begin
					r.ok = 1'b1;
					r.count_out = pool_fill[s];
				end
			end
			gsrp_pkg::CMD_READ: begin
				if (live) begin
					r.count_out = pool_fill[s];
					if (w.rd_index < pool_fill[s]) begin
						idx = s * gsrp_pkg::RECORDS_PER_SLOT + w.rd_index;
						r.ok = 1'b1;
						r.rec_id = pool_recs[idx].id;
						r.rec_kind = pool_recs[idx].kind;
						r.rec_offset = pool_recs[idx].value_offset;
						r.rec_length = pool_recs[idx].value_length;
						r.rec_key_base = pool_recs[idx].key_base;
						r.rec_key_size = pool_recs[idx].key_size;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic row_t mk(input logic [2:0] c, input logic [15:0] s, input logic [15:0] g,
			input logic [7:0] id, input logic [2:0] k, input logic [15:0] vl,
			input logic [15:0] kl, input logic [3:0] ri);
		row_t r;
		r = '0;
		r.w = '{c, s, g, id, k, vl, kl, ri};
		return r;
	endfunction

	function automatic row_t with_exp(input row_t r, input logic ok, input logic [15:0] so,
			input logic [15:0] go, input logic [4:0] cnt);
		r.typed = 1'b1;
		r.want = '0;
		r.want.ok = ok;
		r.want.slot_out = so;
		r.want.generation_out = go;
		r.want.count_out = cnt;
		return r;
	endfunction

	function automatic row_t cfg_row(input logic [15:0] v);
		row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.cfg_val = v;
		return r;
	endfunction

	function automatic gsrp_pkg::item_t random_word();
		gsrp_pkg::item_t w;
		int              r;
		int              s;
		int              start;
		int              lim;
		bit              found;
		w = '0;
		r = $urandom_range(0, 99);
		if (r < 12)
			w.cmd = gsrp_pkg::CMD_ACQUIRE;
		else if (r < 22)
			w.cmd = gsrp_pkg::CMD_RELEASE;
		else if (r < 60)
			w.cmd = gsrp_pkg::CMD_ADD;
		else if (r < 70)
			w.cmd = gsrp_pkg::CMD_COUNT;
		else if (r < 95)
			w.cmd = gsrp_pkg::CMD_READ;
		else
			w.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
		// low slots are favoured so that some reach their record cap
		lim = ($urandom_range(0, 3) != 0) ? 3 : gsrp_pkg::SLOTS - 1;
		start = $urandom_range(0, lim);
		found = 0;
		s = start;
		for (int k = 0; k < gsrp_pkg::SLOTS && !found; k++) begin
			s = (start + k) % gsrp_pkg::SLOTS;
			found = pool_busy[s];
		end
		r = $urandom_range(0, 99);
		if (found && r < 80) begin
			w.slot = 16'(s);
			w.generation = pool_gen[s];
		end else if (found && r < 87) begin
			w.slot = 16'(s);
			w.generation = pool_gen[s] + 16'($urandom_range(1, 3));
		end else if (r < 92) begin
			w.slot = gsrp_pkg::NULL_SLOT;
			w.generation = 16'($urandom);
		end else if (r < 96) begin
			w.slot = 16'($urandom_range(0, gsrp_pkg::SLOTS - 1));
			w.generation = 16'($urandom_range(1, 4));
		end else begin
			w.slot = 16'($urandom);
			w.generation = 16'($urandom);
		end
		w.prop_id = 8'($urandom);
		w.kind = ($urandom_range(0, 9) == 0) ? KIND_BAD :
			3'($urandom_range(KIND_BYTE, gsrp_pkg::KIND_USER));
		w.value_len = ($urandom_range(0, 6) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
		w.key_len = ($urandom_range(0, 6) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
		if (found && $urandom_range(0, 1))
			w.rd_index = 4'($urandom_range(0, (pool_fill[s] > 0) ? pool_fill[s] - 5'd1 : 5'd0));
		else
			w.rd_index = 4'($urandom_range(0, 15));
		return w;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		mismatches++;
		$display("mismatch %s: got %0h, want %0h, cycle %0d", what, got, want, cycle_count);
	endtask

	// entered and left at a falling edge
	task automatic push_word(input gsrp_pkg::item_t w, input bit typed,
			input gsrp_pkg::result_t want);
		int                gap;
		int                r;
		gsrp_pkg::result_t guess;
		r = $urandom_range(0, 99);
		if (burst || r < 60)
			gap = 0;
		else if (r < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(4, 20);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0000, w.rd_index, w.key_len, w.value_len, w.prop_id,
			w.generation, w.slot};
		s_axis_tuser <= {w.kind, w.cmd};
		do @(posedge clk); while (!s_axis_tready);
		guess = pool_outcome(w);
		pending_results.push_back(typed ? want : guess);
		@(negedge clk);
	endtask

	task automatic set_arena_cap(input int v);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v[15:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		arena_cap = v & 16'hFFFF;
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (calm || $urandom_range(0, 99) < 75) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= 1'b0;
			stall_left <= ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2) :
				$urandom_range(5, 20);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen.ok = m_axis_tuser[0];
			seen.rec_kind = m_axis_tuser[3:1];
			seen.slot_out = m_axis_tdata[15:0];
			seen.generation_out = m_axis_tdata[31:16];
			seen.count_out = m_axis_tdata[36:32];
			seen.rec_id = m_axis_tdata[44:37];
			seen.rec_offset = m_axis_tdata[60:45];
			seen.rec_length = m_axis_tdata[76:61];
			seen.rec_key_base = m_axis_tdata[92:77];
			seen.rec_key_size = m_axis_tdata[108:93];
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word, slot_out", seen.slot_out,
					gsrp_pkg::NULL_SLOT);
			end else begin
				owed = pending_results.pop_front();
				if (seen.ok !== owed.ok)
					report_mismatch("ok", 16'(seen.ok), 16'(owed.ok));
				if (seen.slot_out !== owed.slot_out)
					report_mismatch("slot_out", seen.slot_out, owed.slot_out);
				if (seen.generation_out !== owed.generation_out)
					report_mismatch("generation_out", seen.generation_out, owed.generation_out);
				if (seen.count_out !== owed.count_out)
					report_mismatch("count_out", 16'(seen.count_out), 16'(owed.count_out));
				if (seen.rec_id !== owed.rec_id)
					report_mismatch("rec_id", 16'(seen.rec_id), 16'(owed.rec_id));
				if (seen.rec_kind !== owed.rec_kind)
					report_mismatch("rec_kind", 16'(seen.rec_kind), 16'(owed.rec_kind));
				if (seen.rec_offset !== owed.rec_offset)
					report_mismatch("rec_offset", seen.rec_offset, owed.rec_offset);
				if (seen.rec_length !== owed.rec_length)
					report_mismatch("rec_length", seen.rec_length, owed.rec_length);
				if (seen.rec_key_base !== owed.rec_key_base)
					report_mismatch("rec_key_base", seen.rec_key_base, owed.rec_key_base);
				if (seen.rec_key_size !== owed.rec_key_size)
					report_mismatch("rec_key_size", seen.rec_key_size, owed.rec_key_size);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int cap;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		mismatches = 0;
		cycle_count = 0;
		stall_left = 0;
		burst = 0;
		calm = 0;
		arena_top = 0;
		arena_cap = gsrp_pkg::ARENA_LIMIT_RST;
		for (int i = 0; i < gsrp_pkg::SLOTS; i++) begin
			pool_busy[i] = 1'b0;
			pool_gen[i] = gsrp_pkg::GEN_RESET;
			pool_fill[i] = '0;
		end

		plan.push_back(with_exp(mk(gsrp_pkg::CMD_COUNT, gsrp_pkg::NULL_SLOT, 16'd0, 8'd0,
			KIND_BYTE, 16'd0, 16'd0, 4'd0), 1'b0, gsrp_pkg::NULL_SLOT, 16'd0, 5'd0));
		plan.push_back(with_exp(mk(gsrp_pkg::CMD_ACQUIRE, 16'd0, 16'd0, 8'd0, KIND_BYTE,
			16'd0, 16'd0, 4'd0), 1'b1, 16'd0, gsrp_pkg::GEN_RESET, 5'd0));
		plan.push_back(with_exp(mk(gsrp_pkg::CMD_ACQUIRE, gsrp_pkg::NULL_SLOT, 16'hFFFF, 8'hFF,
			KIND_BYTE, 16'd0, 16'd0, 4'd0), 1'b1, 16'd1, gsrp_pkg::GEN_RESET, 5'd0));
		plan.push_back(mk(gsrp_pkg::CMD_ADD, 16'd0, 16'd1, 8'd0, KIND_BYTE, 16'd0, 16'd0, 4'd0));
		plan.push_back(mk(gsrp_pkg::CMD_ADD, 16'd0, 16'd1, 8'hFF, KIND_U16, 16'd2, 16'd7, 4'd0));
		plan.push_back(mk(gsrp_pkg::CMD_ADD, 16'd0, 16'd1, 8'd3, KIND_U32, 16'd4, 16'd0, 4'd0));
		plan.push_back(mk(gsrp_pkg::CMD_ADD, 16'd0, 16'd1, 8'd11, KIND_VARINT, 16'd5, 16'd0,
			4'd0));
		plan.push_back(mk(gsrp_pkg::CMD_ADD, 16'd0, 16'd1, 8'd31, KIND_UTF8, 16'd17, 16'd0,
			4'd0));
		plan.push_back(mk(gsrp_pkg::CMD_ADD, 16'd0, 16'd1, 8'd9, KIND_BINARY, 16'd300, 16'd0,
			4'd0));
		plan.push_back(mk(gsrp_pkg::CMD_ADD, 16'd0, 16'd1, 8'd200, gsrp_pkg::KIND_USER, 16'd9,
			16'd12, 4'd0));
		plan.push_back(with_exp(mk(gsrp_pkg::CMD_ADD, 16'd0, 16'd1, 8'd5, KIND_BAD, 16'd8, 16'd8,
			4'd0), 1'b0, gsrp_pkg::NULL_SLOT, 16'd0, 5'd0));
		// stale handle: key and value space is still consumed
		plan.push_back(mk(gsrp_pkg::CMD_ADD, 16'd1, 16'd2, 8'd5, gsrp_pkg::KIND_USER, 16'd3,
			16'd3, 4'd0));
		plan.push_back(with_exp(mk(gsrp_pkg::CMD_COUNT, 16'd0, 16'd1, 8'd0, KIND_BYTE, 16'd0,
			16'd0, 4'd0), 1'b1, gsrp_pkg::NULL_SLOT, 16'd0, 5'd7));
		plan.push_back(mk(gsrp_pkg::CMD_READ, 16'd0, 16'd1, 8'd0, KIND_BYTE, 16'd0, 16'd0, 4'd0));
		plan.push_back(mk(gsrp_pkg::CMD_READ, 16'd0, 16'd1, 8'd0, KIND_BYTE, 16'd0, 16'd0, 4'd6));
		plan.push_back(mk(gsrp_pkg::CMD_READ, 16'd0, 16'd1, 8'd0, KIND_BYTE, 16'd0, 16'd0, 4'd7));
		plan.push_back(mk(gsrp_pkg::CMD_READ, 16'd0, 16'd1, 8'd0, KIND_BYTE, 16'd0, 16'd0,
			4'd15));
		plan.push_back(mk(gsrp_pkg::CMD_ADD, 16'd31, 16'd1, 8'd1, KIND_U16, 16'd2, 16'd0, 4'd0));
		plan.push_back(mk(gsrp_pkg::CMD_ADD, 16'd40, 16'd1, 8'd1, KIND_U16, 16'd2, 16'd0, 4'd0));
		plan.push_back(with_exp(mk(CMD_SPARE_LO, 16'd0, 16'd1, 8'd0, KIND_BYTE, 16'd0, 16'd0,
			4'd0), 1'b0, gsrp_pkg::NULL_SLOT, 16'd0, 5'd0));
		plan.push_back(with_exp(mk(CMD_SPARE_HI, 16'd0, 16'd1, 8'd0, KIND_BYTE, 16'd0, 16'd0,
			4'd0), 1'b0, gsrp_pkg::NULL_SLOT, 16'd0, 5'd0));
		plan.push_back(with_exp(mk(gsrp_pkg::CMD_RELEASE, 16'd0, 16'd1, 8'd0, KIND_BYTE, 16'd0,
			16'd0, 4'd0), 1'b1, gsrp_pkg::NULL_SLOT, 16'd0, 5'd0));
		plan.push_back(with_exp(mk(gsrp_pkg::CMD_RELEASE, 16'd0, 16'd1, 8'd0, KIND_BYTE, 16'd0,
			16'd0, 4'd0), 1'b0, gsrp_pkg::NULL_SLOT, 16'd0, 5'd0));
		plan.push_back(with_exp(mk(gsrp_pkg::CMD_ACQUIRE, 16'd0, 16'd0, 8'd0, KIND_BYTE, 16'd0,
			16'd0, 4'd0), 1'b1, 16'd0, 16'd2, 5'd0));
		plan.push_back(with_exp(mk(gsrp_pkg::CMD_COUNT, 16'd0, 16'd2, 8'd0, KIND_BYTE, 16'd0,
			16'd0, 4'd0), 1'b1, gsrp_pkg::NULL_SLOT, 16'd0, 5'd0));
		// limit below use: even an empty value is refused
		plan.push_back(cfg_row(16'd0));
		plan.push_back(with_exp(mk(gsrp_pkg::CMD_ADD, 16'd0, 16'd2, 8'd0, KIND_BYTE, 16'd0,
			16'd0, 4'd0), 1'b0, gsrp_pkg::NULL_SLOT, 16'd0, 5'd0));
		plan.push_back(cfg_row(16'hFFFF));
		plan.push_back(with_exp(mk(gsrp_pkg::CMD_ADD, 16'd0, 16'd2, 8'd0, gsrp_pkg::KIND_USER,
			16'hFFFF, 16'hFFFF, 4'd0), 1'b0, gsrp_pkg::NULL_SLOT, 16'd0, 5'd0));
		plan.push_back(with_exp(mk(gsrp_pkg::CMD_RELEASE, gsrp_pkg::NULL_SLOT, 16'hFFFF, 8'd0,
			KIND_BYTE, 16'd0, 16'd0, 4'd0), 1'b0, gsrp_pkg::NULL_SLOT, 16'd0, 5'd0));

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				set_arena_cap(plan[i].cfg_val);
			else
				push_word(plan[i].w, plan[i].typed, plan[i].want);
		end

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: cap = arena_top + $urandom_range(1000, 4000);
				1: cap = arena_top;
				2: cap = (arena_top > 0) ? arena_top - 1 : 0;
				3: cap = arena_top + $urandom_range(3000, 9000);
				default: cap = gsrp_pkg::ARENA_LIMIT_RST;
			endcase
			if (cap > gsrp_pkg::ARENA_LIMIT_RST)
				cap = gsrp_pkg::ARENA_LIMIT_RST;
			set_arena_cap(cap);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (n % 40 == 0) begin
					burst = ($urandom_range(0, 4) == 0);
					calm = ($urandom_range(0, 4) == 0);
				end
				push_word(random_word(), 1'b0, '0);
			end
		end

		s_axis_tvalid <= 1'b0;
		calm = 0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[sim.f]
rtl/core/gsrp_pkg.sv
rtl/core/gsrp_ram.sv
rtl/core/gsrp_slot_table.sv
rtl/core/gsrp_arena.sv
rtl/core/generational_slot_record_pool.sv
rtl/core/gsrp_checker.sv
dv/tb_top.sv
